// ===== rtl/msfd_pkg.sv =====
// ----------------------------------------------------------------------------
// msfd_pkg
// types and constants shared by the sync-word deframer
// ----------------------------------------------------------------------------
package msfd_pkg;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'h54;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h42;

  localparam logic [2:0] HDR_LAST_INDEX = 3'd7;

  localparam logic REG_SYNC_FIRST  = 1'b0;
  localparam logic REG_SYNC_SECOND = 1'b1;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_SYNC1,
    PH_HEADER,
    PH_PAYLOAD
  } phase_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [15:0] payload_len;
    logic [31:0] frame_seq;
    logic [7:0]  data_byte;
    logic        last;
  } result_t;

endpackage

// ===== rtl/msfd_if.sv =====
// ----------------------------------------------------------------------------
// msfd channel interfaces
// valid/ready channels for received bytes and deframed items
// ----------------------------------------------------------------------------
interface msfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       restart;

  modport source (output valid, output rx_byte, output restart, input ready);
  modport sink   (input valid, input rx_byte, input restart, output ready);
endinterface

interface msfd_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  frame_type;
  logic [7:0]  frame_flags;
  logic [15:0] payload_len;
  logic [31:0] frame_seq;
  logic [7:0]  data_byte;
  logic        last;

  modport source (output valid, output item_kind, output frame_type, output frame_flags,
                  output payload_len, output frame_seq, output data_byte, output last,
                  input ready);
  modport sink   (input valid, input item_kind, input frame_type, input frame_flags,
                  input payload_len, input frame_seq, input data_byte, input last,
                  output ready);
endinterface

// ===== rtl/magic_sync_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// magic_sync_frame_deframer_top
// byte-stream deframer: sync hunt, eight-byte header, payload byte items
// ----------------------------------------------------------------------------
// din carries one received byte per item, plus a restart flag that drops any
// partial frame (its byte is discarded). dout carries one header item per
// frame (type, flags, length, 32-bit sequence) followed by one item per
// payload byte; the final item of a frame has last set.
// Throughput is one byte per cycle while dout is not stalled: the frame state
// and the result register are updated in the same cycle the byte is taken, so
// a result appears on dout in the cycle after the byte that causes it.
// The output register is a single stage; din.ready is high while that stage
// is empty or being drained, so a stalled receiver stalls din only once a
// result is waiting.
// cfg_we/cfg_index/cfg_data write the two sync bytes; write only while idle.
// Reset (rst, synchronous) restores sync bytes 0x54/0x42, empties the output
// stage and returns to sync hunting.
// ----------------------------------------------------------------------------
module magic_sync_frame_deframer_top
  import msfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  msfd_in_if.sink    din,
  msfd_out_if.source dout
);

  logic [7:0]  sync_first;
  logic [7:0]  sync_second;

  phase_t      phase;
  phase_t      phase_next;
  logic [2:0]  header_index;
  logic [2:0]  header_index_next;
  logic [7:0]  type_hold;
  logic [7:0]  flags_hold;
  logic [15:0] length_hold;
  logic [23:0] seq_hold;
  logic [15:0] bytes_left;
  logic [15:0] bytes_left_next;

  logic        accept;
  logic        res_valid;
  result_t     res;
  result_t     out_reg;
  logic        out_valid;

  logic [7:0]  b;

  assign b        = din.rx_byte;
  assign din.ready = !out_valid || dout.ready;
  assign accept   = din.valid && din.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_SYNC_FIRST) begin
        sync_first <= cfg_data;
      end else begin
        sync_second <= cfg_data;
      end
    end
  end

  // next state
  always_comb begin
    phase_next        = phase;
    header_index_next = header_index;
    bytes_left_next   = bytes_left;
    if (din.restart) begin
      phase_next        = PH_HUNT;
      header_index_next = '0;
      bytes_left_next   = '0;
    end else begin
      case (phase)
        PH_HUNT: begin
          if (b == sync_first) phase_next = PH_SYNC1;
        end
        PH_SYNC1: begin
          if (b == sync_second) begin
            phase_next        = PH_HEADER;
            header_index_next = '0;
          end else if (b != sync_first) begin
            phase_next = PH_HUNT;
          end
        end
        PH_HEADER: begin
          if (header_index == HDR_LAST_INDEX) begin
            header_index_next = '0;
            bytes_left_next   = length_hold;
            phase_next        = (length_hold == '0) ? PH_HUNT : PH_PAYLOAD;
          end else begin
            header_index_next = header_index + 3'd1;
          end
        end
        PH_PAYLOAD: begin
          if (bytes_left <= 16'd1) begin
            bytes_left_next = '0;
            phase_next      = PH_HUNT;
          end else begin
            bytes_left_next = bytes_left - 16'd1;
          end
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  // result
  always_comb begin
    res_valid       = 1'b0;
    res.item_kind   = KIND_HEADER;
    res.frame_type  = type_hold;
    res.frame_flags = flags_hold;
    res.payload_len = length_hold;
    res.frame_seq   = '0;
    res.data_byte   = '0;
    res.last        = 1'b0;
    if (!din.restart) begin
      case (phase)
        PH_HEADER: begin
          if (header_index == HDR_LAST_INDEX) begin
            res_valid     = 1'b1;
            res.frame_seq = {b, seq_hold};
            res.last      = (length_hold == '0);
          end
        end
        PH_PAYLOAD: begin
          res_valid     = 1'b1;
          res.item_kind = KIND_PAYLOAD;
          res.data_byte = b;
          res.last      = (bytes_left <= 16'd1);
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      header_index <= '0;
      bytes_left   <= '0;
      type_hold    <= '0;
      flags_hold   <= '0;
      length_hold  <= '0;
      seq_hold     <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      header_index <= header_index_next;
      bytes_left   <= bytes_left_next;
      if (!din.restart && phase == PH_HEADER) begin
        case (header_index)
          3'd0:    type_hold          <= b;
          3'd1:    flags_hold         <= b;
          3'd2:    length_hold[7:0]   <= b;
          3'd3:    length_hold[15:8]  <= b;
          3'd4:    seq_hold[7:0]      <= b;
          3'd5:    seq_hold[15:8]     <= b;
          3'd6:    seq_hold[23:16]    <= b;
          default: seq_hold           <= seq_hold;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && res_valid) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_reg <= res;
    end
  end

  assign dout.valid       = out_valid;
  assign dout.item_kind   = out_reg.item_kind;
  assign dout.frame_type  = out_reg.frame_type;
  assign dout.frame_flags = out_reg.frame_flags;
  assign dout.payload_len = out_reg.payload_len;
  assign dout.frame_seq   = out_reg.frame_seq;
  assign dout.data_byte   = out_reg.data_byte;
  assign dout.last        = out_reg.last;

  a_restart_hunts: assert property (@(posedge clk) disable iff (rst)
    accept && din.restart |=> phase == PH_HUNT)
    else $error("restart did not return to hunting");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !dout.ready |-> !din.ready)
    else $error("input taken while result is stalled");

  a_index_only_in_header: assert property (@(posedge clk) disable iff (rst)
    header_index != '0 |-> phase == PH_HEADER)
    else $error("header index set outside header phase");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> bytes_left != '0)
    else $error("payload phase with no bytes left");

  a_payload_seq_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_reg.item_kind == KIND_PAYLOAD |-> out_reg.frame_seq == '0)
    else $error("payload item carries a sequence number");

endmodule
